@@ rtl/psnr_pkg.sv @@
// shared types, character constants and classifier functions for the number recognizer
`default_nettype none

package psnr_pkg;

  localparam int unsigned BASE_MAX = 36;
  localparam int unsigned BASE_SAT = 37;
  localparam int unsigned ACC_W    = 6;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_SIGNED   = 3'd1,
    PH_INTEGER  = 3'd2,
    PH_RADIX    = 3'd3,
    PH_REAL     = 3'd4,
    PH_MAGN     = 3'd5,
    PH_EXPONENT = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    V_SKIP   = 2'd0,
    V_TAKE   = 2'd1,
    V_ACCEPT = 2'd2,
    V_REJECT = 2'd3
  } verdict_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    logic d;
    case (c)
      8'h25, 8'h2F, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E: d = 1'b1;
      default: d = is_space(c);
    endcase
    return d;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  // fold upper-case letters onto lower case
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/postscript_number_recognizer.sv @@
// top level of the byte-serial postscript number recognizer
`default_nettype none

// Scans a byte stream one byte per request and tells, for each byte, whether
// it was skipped as leading whitespace, taken into a number, ended an accepted
// number (the byte itself is not consumed and should be sent again), or
// caused a reject. Signed integers, reals with optional fraction and exponent,
// and unsigned radix numbers base#digits with base 2..36 are recognized. An
// end-of-input request (in_tuser high) ends a number like a delimiter, and at
// the start position it is a reject. Every request yields exactly one result.
// Throughput is one byte per clock while the result channel does not stall: the
// scanner state is a handful of flags and a 6-bit base accumulator, computed
// combinationally from the input register. A request passes the input
// register, then the result register. in_tready follows out_tready
// combinationally when both stages are full.
module postscript_number_recognizer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] ch
  input  wire logic       in_tuser,   // [0] at_end
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [1:0] verdict, [7:2] zero
);

  localparam int unsigned AW = psnr_pkg::ACC_W;

  // input register stage
  logic       s1_valid_r;
  logic [7:0] s1_ch_r;
  logic       s1_end_r;

  // result register stage
  logic                 out_valid_r;
  psnr_pkg::verdict_t   out_verdict_r;

  // scanner state
  psnr_pkg::phase_t phase_r,       phase_nxt;
  logic [AW-1:0]    base_acc_r,    base_acc_nxt;
  logic             sign_seen_r,   sign_seen_nxt;
  logic             mantissa_ok_r, mantissa_ok_nxt;
  logic             radix_ok_r,    radix_ok_nxt;
  logic             exponent_ok_r, exponent_ok_nxt;

  psnr_pkg::verdict_t verdict_c;
  logic               move1;

  // classification of the byte in the input register
  logic       stop_c;
  logic       digit_c;
  logic [7:0] lc_c;
  logic       letter_c;
  logic [8:0] acc_mac_c;    // base_acc * 10 + digit, up to 369 where used (base_acc <= 36)
  logic [AW-1:0] radix_val_c;
  logic [7:0] letter_val_c;
  logic       clear_c;

  // a stage moves when the one after it can take it
  assign move1     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || move1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_verdict_r};

  assign stop_c       = s1_end_r || psnr_pkg::is_delim(s1_ch_r);
  assign digit_c      = psnr_pkg::is_digit(s1_ch_r);
  assign lc_c         = psnr_pkg::to_lower(s1_ch_r);
  assign letter_c     = (lc_c >= psnr_pkg::CH_LO_A) && (lc_c <= psnr_pkg::CH_LO_Z);
  assign acc_mac_c    = {3'd0, base_acc_r} * 9'd10 + {5'd0, s1_ch_r[3:0]};
  // letter value is lc - 'a' + 10
  assign letter_val_c = lc_c - psnr_pkg::CH_LO_A + 8'd10;
  assign radix_val_c  = digit_c ? {2'd0, s1_ch_r[3:0]} : letter_val_c[AW-1:0];

  // next state and verdict for one byte
  always_comb begin
    phase_nxt       = phase_r;
    base_acc_nxt    = base_acc_r;
    sign_seen_nxt   = sign_seen_r;
    mantissa_ok_nxt = mantissa_ok_r;
    radix_ok_nxt    = radix_ok_r;
    exponent_ok_nxt = exponent_ok_r;
    verdict_c       = psnr_pkg::V_TAKE;
    clear_c         = 1'b0;

    case (phase_r)
      psnr_pkg::PH_SIGNED: begin
        if (s1_end_r) begin
          clear_c   = 1'b1;
          verdict_c = psnr_pkg::V_REJECT;
        end else if (digit_c) begin
          base_acc_nxt    = {2'd0, s1_ch_r[3:0]};
          mantissa_ok_nxt = 1'b1;
          phase_nxt       = psnr_pkg::PH_INTEGER;
        end else if (s1_ch_r == psnr_pkg::CH_DOT) begin
          phase_nxt = psnr_pkg::PH_REAL;
        end else begin
          clear_c   = 1'b1;
          verdict_c = psnr_pkg::V_REJECT;
        end
      end

      psnr_pkg::PH_INTEGER: begin
        if (stop_c) begin
          clear_c   = 1'b1;
          verdict_c = mantissa_ok_r ? psnr_pkg::V_ACCEPT : psnr_pkg::V_REJECT;
        end else if (digit_c) begin
          // saturate the leading value once it cannot be a base any more
          if (base_acc_r <= AW'(psnr_pkg::BASE_MAX)) begin
            base_acc_nxt = (acc_mac_c > 9'(psnr_pkg::BASE_MAX)) ?
                           AW'(psnr_pkg::BASE_SAT) : acc_mac_c[AW-1:0];
          end
          mantissa_ok_nxt = 1'b1;
        end else if (s1_ch_r == psnr_pkg::CH_HASH) begin
          if (base_acc_r < AW'(2) || base_acc_r > AW'(psnr_pkg::BASE_MAX) || sign_seen_r) begin
            clear_c   = 1'b1;
            verdict_c = psnr_pkg::V_REJECT;
          end else begin
            phase_nxt = psnr_pkg::PH_RADIX;
          end
        end else if (s1_ch_r == psnr_pkg::CH_DOT) begin
          phase_nxt = psnr_pkg::PH_REAL;
        end else if (lc_c == psnr_pkg::CH_LO_E) begin
          phase_nxt = psnr_pkg::PH_MAGN;
        end else begin
          clear_c   = 1'b1;
          verdict_c = psnr_pkg::V_REJECT;
        end
      end

      psnr_pkg::PH_RADIX: begin
        if (stop_c) begin
          clear_c   = 1'b1;
          verdict_c = radix_ok_r ? psnr_pkg::V_ACCEPT : psnr_pkg::V_REJECT;
        end else if (!(digit_c || letter_c) || radix_val_c >= base_acc_r) begin
          clear_c   = 1'b1;
          verdict_c = psnr_pkg::V_REJECT;
        end else begin
          radix_ok_nxt = 1'b1;
        end
      end

      psnr_pkg::PH_REAL: begin
        if (stop_c) begin
          clear_c   = 1'b1;
          verdict_c = mantissa_ok_r ? psnr_pkg::V_ACCEPT : psnr_pkg::V_REJECT;
        end else if (digit_c) begin
          mantissa_ok_nxt = 1'b1;
        end else if (lc_c == psnr_pkg::CH_LO_E && mantissa_ok_r) begin
          phase_nxt = psnr_pkg::PH_MAGN;
        end else begin
          clear_c   = 1'b1;
          verdict_c = psnr_pkg::V_REJECT;
        end
      end

      psnr_pkg::PH_MAGN: begin
        if (stop_c) begin
          clear_c   = 1'b1;
          verdict_c = psnr_pkg::V_REJECT;
        end else if (s1_ch_r == psnr_pkg::CH_PLUS || s1_ch_r == psnr_pkg::CH_MINUS) begin
          phase_nxt = psnr_pkg::PH_EXPONENT;
        end else if (digit_c) begin
          exponent_ok_nxt = 1'b1;
          phase_nxt       = psnr_pkg::PH_EXPONENT;
        end else begin
          clear_c   = 1'b1;
          verdict_c = psnr_pkg::V_REJECT;
        end
      end

      psnr_pkg::PH_EXPONENT: begin
        if (stop_c) begin
          clear_c   = 1'b1;
          verdict_c = (mantissa_ok_r && exponent_ok_r) ?
                      psnr_pkg::V_ACCEPT : psnr_pkg::V_REJECT;
        end else if (digit_c) begin
          exponent_ok_nxt = 1'b1;
        end else begin
          clear_c   = 1'b1;
          verdict_c = psnr_pkg::V_REJECT;
        end
      end

      // start phase, also taken by the unused code
      default: begin
        clear_c = 1'b1;
        if (s1_end_r) begin
          verdict_c = psnr_pkg::V_REJECT;
        end else if (psnr_pkg::is_space(s1_ch_r)) begin
          verdict_c = psnr_pkg::V_SKIP;
        end else if (s1_ch_r == psnr_pkg::CH_PLUS || s1_ch_r == psnr_pkg::CH_MINUS) begin
          clear_c       = 1'b0;
          base_acc_nxt  = '0;
          mantissa_ok_nxt = 1'b0;
          radix_ok_nxt  = 1'b0;
          exponent_ok_nxt = 1'b0;
          sign_seen_nxt = 1'b1;
          phase_nxt     = psnr_pkg::PH_SIGNED;
        end else if (digit_c) begin
          clear_c         = 1'b0;
          base_acc_nxt    = {2'd0, s1_ch_r[3:0]};
          sign_seen_nxt   = 1'b0;
          mantissa_ok_nxt = 1'b1;
          radix_ok_nxt    = 1'b0;
          exponent_ok_nxt = 1'b0;
          phase_nxt       = psnr_pkg::PH_INTEGER;
        end else if (s1_ch_r == psnr_pkg::CH_DOT) begin
          clear_c         = 1'b0;
          base_acc_nxt    = '0;
          sign_seen_nxt   = 1'b0;
          mantissa_ok_nxt = 1'b0;
          radix_ok_nxt    = 1'b0;
          exponent_ok_nxt = 1'b0;
          phase_nxt       = psnr_pkg::PH_REAL;
        end else begin
          verdict_c = psnr_pkg::V_REJECT;
        end
      end
    endcase

    // accept, reject and skip all leave the scanner at start
    if (clear_c) begin
      phase_nxt       = psnr_pkg::PH_START;
      base_acc_nxt    = '0;
      sign_seen_nxt   = 1'b0;
      mantissa_ok_nxt = 1'b0;
      radix_ok_nxt    = 1'b0;
      exponent_ok_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= psnr_pkg::PH_START;
      base_acc_r    <= '0;
      sign_seen_r   <= 1'b0;
      mantissa_ok_r <= 1'b0;
      radix_ok_r    <= 1'b0;
      exponent_ok_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (!out_valid_r || out_tready) begin
        out_valid_r <= s1_valid_r;
      end
      if (move1) begin
        phase_r       <= phase_nxt;
        base_acc_r    <= base_acc_nxt;
        sign_seen_r   <= sign_seen_nxt;
        mantissa_ok_r <= mantissa_ok_nxt;
        radix_ok_r    <= radix_ok_nxt;
        exponent_ok_r <= exponent_ok_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_ch_r  <= in_tdata;
      s1_end_r <= in_tuser;
    end
    if (move1) begin
      out_verdict_r <= verdict_c;
    end
  end

  // a finished number always leaves a clean start state
  a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    move1 && (verdict_c == psnr_pkg::V_ACCEPT || verdict_c == psnr_pkg::V_REJECT)
    |=> phase_r == psnr_pkg::PH_START && base_acc_r == '0 && !sign_seen_r)
    else $error("scanner state not cleared after accept or reject");

  // radix digits are only scanned under a legal base
  a_radix_base: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == psnr_pkg::PH_RADIX
    |-> base_acc_r >= AW'(2) && base_acc_r <= AW'(psnr_pkg::BASE_MAX) && !sign_seen_r)
    else $error("radix phase with illegal base");

  // the integer phase is entered only with a digit in hand
  a_integer_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == psnr_pkg::PH_INTEGER |-> mantissa_ok_r)
    else $error("integer phase without a mantissa digit");

  // the base accumulator never passes its saturation value
  a_acc_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    base_acc_r <= AW'(psnr_pkg::BASE_SAT))
    else $error("base accumulator out of range");

  // a stalled input register keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !move1 |=> s1_valid_r && $stable(s1_ch_r) && $stable(s1_end_r))
    else $error("input register lost a stalled request");

endmodule

`default_nettype wire

@@ test/psnr_verdict_checker.sv @@
// verdict predictor and comparator that watches both streams of the number recognizer
module psnr_verdict_checker
  import psnr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tuser,   // [0] at_end
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [1:0] verdict, [7:2] zero
  output int         fail_count,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow scanner state
  phase_t     ph;
  logic [5:0] acc;
  logic       signed_num;
  logic       mant_seen;
  logic       radix_seen;
  logic       exp_seen;

  verdict_t   due_verdicts[$];

  function automatic logic blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic separator(input logic [7:0] c);
    return blank(c) ||
           c inside {8'h25, 8'h2F, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3C, 8'h3E};
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  function automatic void clear_scan();
    ph         = PH_START;
    acc        = '0;
    signed_num = 1'b0;
    mant_seen  = 1'b0;
    radix_seen = 1'b0;
    exp_seen   = 1'b0;
  endfunction

  function automatic verdict_t close_number(input logic ok);
    clear_scan();
    return ok ? V_ACCEPT : V_REJECT;
  endfunction

  // one scanner step: updates the shadow state, returns the verdict for this byte
  function automatic verdict_t scan_byte(input logic [7:0] c, input logic eoi);
    logic        stop;
    logic [7:0]  lc;
    logic [5:0]  dval;
    int unsigned acc_next;
    stop = eoi || separator(c);
    lc   = (c >= 8'h41 && c <= 8'h5A) ? 8'(c + 8'd32) : c;
    case (ph)
      PH_SIGNED: begin
        if (eoi) return close_number(1'b0);
        if (numeral(c)) begin
          acc       = 6'(c - CH_ZERO);
          mant_seen = 1'b1;
          ph        = PH_INTEGER;
          return V_TAKE;
        end
        if (c == CH_DOT) begin
          ph = PH_REAL;
          return V_TAKE;
        end
        return close_number(1'b0);
      end
      PH_INTEGER: begin
        if (stop) return close_number(mant_seen);
        if (numeral(c)) begin
          if (int'(acc) <= BASE_MAX) begin
            acc_next = int'(acc) * 10 + int'(c - CH_ZERO);
            acc      = (acc_next > BASE_MAX) ? 6'(BASE_SAT) : 6'(acc_next);
          end
          mant_seen = 1'b1;
          return V_TAKE;
        end
        if (c == CH_HASH) begin
          if (int'(acc) < 2 || int'(acc) > BASE_MAX || signed_num) return close_number(1'b0);
          ph = PH_RADIX;
          return V_TAKE;
        end
        if (c == CH_DOT) begin
          ph = PH_REAL;
          return V_TAKE;
        end
        if (lc == CH_LO_E) begin
          ph = PH_MAGN;
          return V_TAKE;
        end
        return close_number(1'b0);
      end
      PH_RADIX: begin
        if (stop) return close_number(radix_seen);
        if (numeral(c)) dval = 6'(c - CH_ZERO);
        else if (lc >= CH_LO_A && lc <= CH_LO_Z) dval = 6'(lc - CH_LO_A + 8'd10);
        else return close_number(1'b0);
        // digit must stay below the base
        if (dval >= acc) return close_number(1'b0);
        radix_seen = 1'b1;
        return V_TAKE;
      end
      PH_REAL: begin
        if (stop) return close_number(mant_seen);
        if (numeral(c)) begin
          mant_seen = 1'b1;
          return V_TAKE;
        end
        if (lc == CH_LO_E) begin
          if (!mant_seen) return close_number(1'b0);
          ph = PH_MAGN;
          return V_TAKE;
        end
        return close_number(1'b0);
      end
      PH_MAGN: begin
        if (stop) return close_number(1'b0);
        if (c == CH_PLUS || c == CH_MINUS) begin
          ph = PH_EXPONENT;
          return V_TAKE;
        end
        if (numeral(c)) begin
          exp_seen = 1'b1;
          ph       = PH_EXPONENT;
          return V_TAKE;
        end
        return close_number(1'b0);
      end
      PH_EXPONENT: begin
        if (stop) return close_number(mant_seen && exp_seen);
        if (numeral(c)) begin
          exp_seen = 1'b1;
          return V_TAKE;
        end
        return close_number(1'b0);
      end
      default: begin
        clear_scan();
        if (eoi) return V_REJECT;
        if (blank(c)) return V_SKIP;
        if (c == CH_PLUS || c == CH_MINUS) begin
          signed_num = 1'b1;
          ph         = PH_SIGNED;
          return V_TAKE;
        end
        if (numeral(c)) begin
          acc       = 6'(c - CH_ZERO);
          mant_seen = 1'b1;
          ph        = PH_INTEGER;
          return V_TAKE;
        end
        if (c == CH_DOT) begin
          ph = PH_REAL;
          return V_TAKE;
        end
        return V_REJECT;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      clear_scan();
      due_verdicts.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (in_tvalid && in_tready) due_verdicts.push_back(scan_byte(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (due_verdicts.size() == 0) begin
          $display("%0t: result %0h with no request waiting, expected none", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = due_verdicts.pop_front();
          if (out_tdata !== {6'b0, want}) begin
            $display("%0t: verdict mismatch, expected %s (%0h) got %0h",
                     $time, want.name(), {6'b0, want}, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
      outstanding <= due_verdicts.size();
    end
  end

endmodule

@@ test/postscript_number_recognizer_tb.sv @@
// stimulus, handshake pacing and verdict for the postscript number recognizer
module postscript_number_recognizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psnr_pkg::*;

  // random part stops once this many requests are queued
  localparam int RANDOM_ITEMS = 1150;
  // cycles without any handshake before the run is declared hung
  localparam int IDLE_LIMIT   = 2000;
  // cycles allowed after the last result
  localparam int TAIL_CYCLES  = 6;

  // one request on the input stream
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } scan_req_t;

  // receiver back-pressure styles
  typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_MASK} rx_mode_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] ch
  logic       in_tuser   = 1'b0;   // [0] at_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [1:0] verdict, [7:2] zero

  int         fail_count;
  int         outstanding;
  int         idle_cycles = 0;

  scan_req_t  byte_stream[$];

  rx_mode_t   rx_mode    = RX_OPEN;
  int         rx_left    = 0;
  int         rx_tick    = 0;
  logic [7:0] rx_mask    = 8'hFF;

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  postscript_number_recognizer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  psnr_verdict_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // receiver: switches between stall styles after random stretches,
  // fully open stretches included so back-to-back results also occur
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
      rx_mask = 8'($urandom_range(0, 255));
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN: out_tready <= 1'b1;
      RX_COIN: out_tready <= 1'($urandom_range(0, 1));
      RX_SLOW: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= rx_mask[rx_tick % 8];
    endcase
  end

  // watchdog: any handshake on either stream restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic put_byte(input logic [7:0] c, input logic eoi);
    byte_stream.push_back('{ch: c, eoi: eoi});
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endtask

  // optional sign, present with odds of one in one_in
  task automatic put_sign(input int one_in);
    if ($urandom_range(1, one_in) == 1) put_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0);
  endtask

  task automatic put_decimal(input int n);
    repeat (n) put_byte(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
  endtask

  // one random token, mostly well-formed numbers, then an optional terminator
  task automatic make_token();
    int         kind;
    int         base;
    int         val;
    logic [7:0] c;
    string      pick;
    string      delims;
    pick   = "0123456789+-.#eEaZ";
    delims = "%/()[]{}<>";
    kind   = $urandom_range(0, 99);
    if (kind < 22) begin
      // signed integer
      put_sign(3);
      put_decimal($urandom_range(1, 6));
    end else if (kind < 44) begin
      // real, fraction and exponent parts may be empty
      put_sign(3);
      put_decimal($urandom_range(0, 4));
      put_byte(CH_DOT, 1'b0);
      put_decimal($urandom_range(0, 4));
      if ($urandom_range(0, 1)) begin
        put_byte($urandom_range(0, 1) ? CH_LO_E : 8'h45, 1'b0);
        put_sign(2);
        put_decimal($urandom_range(0, 3));
      end
    end else if (kind < 66) begin
      // radix number, now and then with a bad base, a sign or a leading zero
      base = ($urandom_range(0, 4) != 0) ? $urandom_range(2, 36) : $urandom_range(0, 120);
      if ($urandom_range(0, 9) == 0) put_sign(1);
      if ($urandom_range(0, 9) == 0) put_byte(CH_ZERO, 1'b0);
      if (base >= 100) put_byte(8'(CH_ZERO + base / 100), 1'b0);
      if (base >= 10) put_byte(8'(CH_ZERO + (base / 10) % 10), 1'b0);
      put_byte(8'(CH_ZERO + base % 10), 1'b0);
      put_byte(CH_HASH, 1'b0);
      repeat ($urandom_range(0, 5)) begin
        if ($urandom_range(0, 6) != 0 && base >= 2 && base <= 36)
          val = $urandom_range(0, base - 1);
        else
          val = $urandom_range(0, 35);
        if (val < 10) put_byte(8'(CH_ZERO + val), 1'b0);
        else put_byte(8'(($urandom_range(0, 1) ? CH_LO_A : 8'h41) + val - 10), 1'b0);
      end
    end else if (kind < 76) begin
      // whitespace run: space, tab, lf, vt, ff, cr
      repeat ($urandom_range(1, 4)) begin
        val = $urandom_range(8, 13);
        put_byte(val == 8 ? 8'h20 : 8'(val), 1'b0);
      end
      return;
    end else if (kind < 86) begin
      // arbitrary bytes
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      // broken number-like fragments
      repeat ($urandom_range(1, 5)) put_byte(pick[$urandom_range(0, pick.len() - 1)], 1'b0);
    end
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      put_byte(kind < 30 ? 8'h20 : 8'h0A, 1'b0);
    end else if (kind < 65) begin
      // a delimiter that ends a number is not consumed, so send it again at times
      c = delims[$urandom_range(0, delims.len() - 1)];
      put_byte(c, 1'b0);
      if ($urandom_range(0, 1)) put_byte(c, 1'b0);
    end else if (kind < 75) begin
      // end of input, with a random byte that must be ignored
      put_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // hold one request until the handshake, then step to the next falling edge
  task automatic push_byte(input scan_req_t r);
    in_tdata  <= r.ch;
    in_tuser  <= r.eoi;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
  endtask

  // send the queued stream in bursts with random gaps; at pause_at the sender
  // stops until every result is back
  task automatic send_stream(input int pause_at);
    int burst_left;
    int gap;
    burst_left = 0;
    foreach (byte_stream[i]) begin
      if (i == pause_at) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        drain();
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        // about one burst in four follows the previous one without a gap
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          in_tdata  <= 8'($urandom_range(0, 255));
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
      push_byte(byte_stream[i]);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    // reset held low at start, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    put_byte(8'h00, 1'b1);    // end of input at start
    put_byte(8'h00, 1'b0);    // nul cannot start a number
    put_byte(8'hFF, 1'b0);    // high byte is an ordinary character
    put_text(" ");            // whitespace skipped
    put_text("+-");           // sign followed by a second sign
    put_text("-");            // sign followed by end of input
    put_byte(8'hFF, 1'b1);
    put_text(". ");           // lone dot
    put_text("1#");           // base below two
    put_text("2#2");          // radix digit equal to the base
    put_text("1e");           // exponent with no digits
    put_byte(8'h00, 1'b1);
    put_text("36#Z");         // largest base, largest digit, ended by end of input
    put_byte(8'hFF, 1'b1);
    send_stream(-1);
    @(negedge clk);
    // sender holds off until the directed results are all back
    drain();

    // random part, with one more full hold-off halfway through
    byte_stream.delete();
    while (byte_stream.size() < RANDOM_ITEMS) make_token();
    send_stream(byte_stream.size() / 2);

    @(negedge clk);
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
